>>> rtl/core/fas_pkg.sv
`default_nettype none
package fas_pkg;

    localparam int MANT_W = 23;
    localparam int EXP_W  = 8;
    localparam int SIG_W  = MANT_W + 2;   // carry bit, hidden one, fraction
    localparam int LZ_W   = 5;
    localparam logic [EXP_W-1:0] GAP_LIMIT = 8'd25;

    typedef struct packed {
        logic        kind;
        logic [31:0] a_bits;
        logic [31:0] b_bits;
    } fas_req_t;

    typedef struct packed {
        logic [31:0] sum_bits;
    } fas_rsp_t;

    // stage 1 -> 2: ordered operands, aligned smaller significand
    typedef struct packed {
        logic              sign;
        logic              sub;
        logic [EXP_W-1:0]  ex;
        logic [SIG_W-1:0]  mx;
        logic [SIG_W-1:0]  my;
    } fas_align_t;

    // stage 2 -> 3: raw sum with leading-zero count
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic              carry;
        logic [EXP_W-1:0]  ex;
        logic [SIG_W-1:0]  m;
        logic [LZ_W-1:0]   lz;
    } fas_sum_t;

endpackage
`default_nettype wire

>>> rtl/core/fas_stream_if.sv
`default_nettype none
interface fas_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fas_align.sv
`default_nettype none
module fas_align
    import fas_pkg::*;
(
    input  wire logic       kind,
    input  wire logic [31:0] a_bits,
    input  wire logic [31:0] b_bits,
    output fas_align_t       align
);
    logic [31:0]      bb, x, y;
    logic [EXP_W-1:0] gap;
    logic [SIG_W-1:0] my_full;

    // flip sign for subtract, order by magnitude, shift smaller significand
    always_comb
    begin
        bb = {b_bits[31] ^ kind, b_bits[30:0]};
        if (a_bits[30:0] < bb[30:0])
        begin
            x = bb;
            y = a_bits;
        end
        else
        begin
            x = a_bits;
            y = bb;
        end
        gap = x[30:23] - y[30:23];
        my_full = {2'b01, y[22:0]};
        align.sign = x[31];
        align.sub  = x[31] ^ y[31];
        align.ex   = x[30:23];
        align.mx   = {2'b01, x[22:0]};
        align.my   = (gap >= GAP_LIMIT) ? '0 : (my_full >> gap);
    end
endmodule
`default_nettype wire

>>> rtl/core/fas_addlz.sv
`default_nettype none
module fas_addlz
    import fas_pkg::*;
(
    input  fas_align_t align,
    output fas_sum_t   sum
);
    logic [SIG_W-1:0] m;
    logic [LZ_W-1:0]  lz;

    // add or subtract, then count leading zeros below the hidden-one position
    always_comb
    begin
        m = align.sub ? (align.mx - align.my) : (align.mx + align.my);
        lz = '0;
        for (int i = 0; i <= MANT_W; i++)
        begin
            if (m[i])
                lz = LZ_W'(MANT_W - i);
        end
        sum.sign  = align.sign;
        sum.zero  = (m == '0);
        sum.carry = m[SIG_W-1];
        sum.ex    = align.ex;
        sum.m     = m;
        sum.lz    = lz;
    end
endmodule
`default_nettype wire

>>> rtl/core/fas_norm.sv
`default_nettype none
module fas_norm
    import fas_pkg::*;
(
    input  fas_sum_t    sum,
    output logic [31:0] sum_bits
);
    logic [SIG_W-1:0] mn;
    logic [EXP_W-1:0] en;

    // one right shift on carry, otherwise left shift by the zero count
    always_comb
    begin
        if (sum.carry)
        begin
            mn = sum.m >> 1;
            en = sum.ex + 8'd1;
        end
        else
        begin
            mn = sum.m << sum.lz;
            en = sum.ex - EXP_W'(sum.lz);
        end
        sum_bits = sum.zero ? 32'd0 : {sum.sign, en, mn[MANT_W-1:0]};
    end
endmodule
`default_nettype wire

>>> rtl/core/float32_add_sub_top.sv
`default_nettype none
// Truncating single-precision add/subtract, four register stages: input,
// align, add with leading-zero count, normalize into the output register.
// A transaction enters every cycle unless a stall has filled every stage; its
// result passes the align and sum registers on its way to the output register.
// Valid bits travel with each stage and a stage advances whenever the stage
// after it is empty or moving, so a stall on the output holds every full
// stage and bubbles ahead of it are squeezed out.
// No rounding, no special values; the exponent wraps modulo 256.
module float32_add_sub_top
    import fas_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fas_stream_if.sink   in_ch,
    fas_stream_if.source out_ch
);
    logic       v0_reg, v1_reg, v2_reg, v3_reg;
    logic       en0, en1, en2, en3;
    fas_req_t   req_reg;
    fas_align_t al_next, al_reg;
    fas_sum_t   sm_next, sm_reg;
    logic [31:0] out_next, out_reg;

    // advance enables, back to front
    assign en3 = !v3_reg || out_ch.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign in_ch.ready = en0;

    fas_align u_align (.kind(req_reg.kind), .a_bits(req_reg.a_bits),
                       .b_bits(req_reg.b_bits), .align(al_next));
    fas_addlz u_addlz (.align(al_reg), .sum(sm_next));
    fas_norm  u_norm  (.sum(sm_reg), .sum_bits(out_next));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_ch.valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en0) req_reg <= in_ch.payload;
        if (en1) al_reg  <= al_next;
        if (en2) sm_reg  <= sm_next;
        if (en3) out_reg <= out_next;
    end

    assign out_ch.valid            = v3_reg;
    assign out_ch.payload.sum_bits = out_reg;

`ifndef NO_ASSERTIONS
    // a stalled output holds its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_reg))
        else $error("output changed under stall");
    // a full pipe under stall refuses input
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg && v1_reg && v2_reg && v3_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("full pipeline accepted input");
    // normalized results keep the hidden one
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !sm_reg.zero && !sm_reg.carry |-> sm_reg.m[MANT_W + LZ_W'(0) - sm_reg.lz])
        else $error("leading zero count wrong");
`endif
endmodule
`default_nettype wire
